// ----- src/mrw_pkg.sv -----
// Package with shared widths and control structs for the witness test.
package mrw_pkg;
  localparam int WIDTH = 31;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  // Request to the shared modular multiplier.
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t n;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t p;
  } mul_rsp_t;
endpackage

// ----- src/miller_rabin_witness_test_top.sv -----
// Top level of the Miller-Rabin witness test: sequencer around a shared modular multiplier.
//
//   Channel | Ports                                   | Direction
//   in      | in_valid/in_ready, candidate/base/last  | into block
//   out     | out_valid/out_ready, is_witness/...     | out of block
//
// One transaction splits n-1, reduces the base, then runs the modular products, with
// at most 2*WIDTH-2 products when n-1 is twice an all-ones odd part.
// A candidate below 3 skips straight to the result.
// The shared shift-subtract multiplier folds in one bit per cycle.
// Reset clears the sequencer and the sticky composite flag.
// The block accepts no input while a transaction is in work or its result waits.
module miller_rabin_witness_test_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_candidate,
  input  logic [30:0] in_base,
  input  logic        in_last_base,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_witness,
  output logic        out_composite,
  output logic        out_run_done
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SPLIT = 4'd1;
  localparam logic [3:0] S_RED  = 4'd2;
  localparam logic [3:0] S_PMUL = 4'd3;
  localparam logic [3:0] S_PSQ  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_SQ   = 4'd6;
  localparam logic [3:0] S_SQW  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_PW   = 4'd9;

  localparam int W = mrw_pkg::WIDTH;

  logic [3:0] st_r, st_nxt;
  mrw_pkg::word_t n_r, n_nxt, a_r, a_nxt, u_r, u_nxt, x_r, x_nxt, sq_r, sq_nxt;
  logic [mrw_pkg::CNT_W-1:0] t_r, t_nxt, i_r, i_nxt;
  logic last_r, last_nxt, wit_r, wit_nxt, seen_r, seen_nxt;
  logic mulsq_r, mulsq_nxt;
  mrw_pkg::mul_req_t req;
  mrw_pkg::mul_rsp_t rsp;
  mrw_pkg::word_t nm1;

  mrw_modmul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign nm1 = n_r - 1'b1;
  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_is_witness = wit_r;
  assign out_composite = seen_r | wit_r;
  assign out_run_done = last_r;

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; a_nxt = a_r; u_nxt = u_r; x_nxt = x_r;
    sq_nxt = sq_r; t_nxt = t_r; i_nxt = i_r; last_nxt = last_r;
    wit_nxt = wit_r; seen_nxt = seen_r; mulsq_nxt = mulsq_r;
    req.start = 1'b0; req.a = '0; req.b = '0; req.n = n_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt = in_candidate[W-1:0];
          a_nxt = in_base[W-1:0];
          last_nxt = in_last_base;
          u_nxt = in_candidate[W-1:0] - 1'b1;
          t_nxt = '0;
          wit_nxt = 1'b0;
          st_nxt = (in_candidate[W-1:0] < mrw_pkg::word_t'(3)) ? S_OUT : S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (!u_r[0] && t_r < mrw_pkg::CNT_W'(W)) begin
          u_nxt = u_r >> 1;
          t_nxt = t_r + 1'b1;
        end else begin
          // a mod n as 1*a mod n keeps every reduction in the shared unit; the
          // unit folds in one bit of its second operand per cycle, so any
          // WIDTH-bit base is reduced in full there.
          req.start = 1'b1; req.a = mrw_pkg::word_t'(1); req.b = a_r;
          st_nxt = S_RED;
        end
      end
      S_RED: if (rsp.done) begin
        sq_nxt = rsp.p;
        x_nxt = mrw_pkg::word_t'(1);
        st_nxt = S_PW;
      end
      S_PW: begin
        if (u_r == '0) begin
          st_nxt = S_CHK;
        end else if (u_r[0] && !mulsq_r) begin
          req.start = 1'b1; req.a = x_r; req.b = sq_r;
          st_nxt = S_PMUL;
        end else begin
          req.start = 1'b1; req.a = sq_r; req.b = sq_r;
          st_nxt = S_PSQ;
        end
      end
      S_PMUL: if (rsp.done) begin
        x_nxt = rsp.p; mulsq_nxt = 1'b1; st_nxt = S_PW;
      end
      S_PSQ: if (rsp.done) begin
        sq_nxt = rsp.p; mulsq_nxt = 1'b0; u_nxt = u_r >> 1; st_nxt = S_PW;
      end
      S_CHK: begin
        i_nxt = mrw_pkg::CNT_W'(1);
        if (x_r == mrw_pkg::word_t'(1) || x_r == nm1) begin
          wit_nxt = 1'b0; st_nxt = S_OUT;
        end else begin
          st_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (i_r < t_r) begin
          req.start = 1'b1; req.a = x_r; req.b = x_r;
          st_nxt = S_SQW;
        end else begin
          wit_nxt = 1'b1; st_nxt = S_OUT;
        end
      end
      S_SQW: if (rsp.done) begin
        x_nxt = rsp.p;
        i_nxt = i_r + 1'b1;
        if (rsp.p == nm1) begin
          wit_nxt = 1'b0; st_nxt = S_OUT;
        end else begin
          st_nxt = S_SQ;
        end
      end
      S_OUT: if (out_ready) begin
        seen_nxt = last_r ? 1'b0 : (seen_r | wit_r);
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      seen_r <= 1'b0;
      mulsq_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      seen_r <= seen_nxt;
      mulsq_r <= mulsq_nxt;
    end
    n_r <= n_nxt; a_r <= a_nxt; u_r <= u_nxt; x_r <= x_nxt; sq_r <= sq_nxt;
    t_r <= t_nxt; i_r <= i_nxt; last_r <= last_nxt; wit_r <= wit_nxt;
  end

  // A new transaction is never taken while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid overlap");
  // The multiplier is started only on a move into a sequencer state that waits on it.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (st_r == S_RED || st_r == S_PMUL || st_r == S_PSQ || st_r == S_SQW))
    else $error("multiplier started without a waiting state");
  // The sticky flag clears after the last base is delivered.
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_run_done) |=> !seen_r)
    else $error("composite flag not cleared");
endmodule

// ----- src/mrw_modmul.sv -----
// Interleaved shift-subtract modular multiplier, one bit of b per cycle.
module mrw_modmul (
  input  logic              clk,
  input  logic              rst_n,
  input  mrw_pkg::mul_req_t req,
  output mrw_pkg::mul_rsp_t rsp
);
  logic                    busy_r, busy_nxt;
  logic [mrw_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  mrw_pkg::word_t          a_r, a_nxt, b_r, b_nxt, n_r, n_nxt;
  logic [mrw_pkg::WIDTH:0] r_r, r_nxt;
  logic                    done_r, done_nxt;
  logic [mrw_pkg::WIDTH+1:0] sh, s1, ad, s2;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    n_nxt    = n_r;
    r_nxt    = r_r;
    done_nxt = 1'b0;
    sh = {r_r, 1'b0};
    s1 = (sh >= {2'b00, n_r}) ? sh - {2'b00, n_r} : sh;
    ad = b_r[mrw_pkg::WIDTH-1] ? s1 + {2'b00, a_r} : s1;
    s2 = (ad >= {2'b00, n_r}) ? ad - {2'b00, n_r} : ad;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mrw_pkg::CNT_W'(mrw_pkg::WIDTH);
      a_nxt    = req.a;
      b_nxt    = req.b;
      n_nxt    = req.n;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt   = s2[mrw_pkg::WIDTH:0];
      b_nxt   = {b_r[mrw_pkg::WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == mrw_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    n_r <= n_nxt;
    r_r <= r_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = r_r[mrw_pkg::WIDTH-1:0];
endmodule
